### src/fhpl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Flash halfword program loader package
// Job codes, command constants and the job record passed from the front end
// to the back end.
// ----------------------------------------------------------------------------
package fhpl_pkg;

	localparam logic [31:0] TOKEN_START = 32'h4D52_4140;
	localparam logic [31:0] REPLY_ACK   = 32'h216B_6361;
	localparam logic [31:0] REPLY_FIN   = 32'h216E_6966;
	localparam logic [31:0] REPLY_NACK  = 32'h6B63_614E;

	localparam logic [15:0] CMD_UNLOCK1 = 16'hAAAA;
	localparam logic [15:0] CMD_UNLOCK2 = 16'h5555;
	localparam logic [15:0] CMD_PROGRAM = 16'hA0A0;
	localparam logic [15:0] CMD_RESET   = 16'hF0F0;

	localparam logic [31:0] OFS_CMD1 = 32'h0000_0AAA;
	localparam logic [31:0] OFS_CMD2 = 32'h0000_0554;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_REPLY = 2'd2;

	localparam logic [15:0] POLL_MASK  = 16'h8080;
	localparam int unsigned DQ5_BIT    = 5;
	localparam int unsigned DQ7_BIT    = 7;

	typedef enum logic [2:0] {
		JOB_ACK,
		JOB_ACK_FIN,
		JOB_PROG,
		JOB_READ,
		JOB_FIN,
		JOB_NACK
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [31:0] base;
		logic [31:0] ptr;
		logic [15:0] data;
	} job_t;

endpackage
`default_nettype wire

### src/fhpl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Flash halfword program loader front end
// Accepts input words, runs the protocol state and posts at most one job per word.
// ----------------------------------------------------------------------------
module fhpl_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic         req_type,
	input  wire logic [31:0]  host_word,
	input  wire logic [15:0]  flash_read_data,
	input  wire logic         queue_full,
	output logic              push,
	output fhpl_pkg::job_t    push_job
);
	import fhpl_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BASE,
		PH_ADDR,
		PH_LEN,
		PH_DATA,
		PH_POLL,
		PH_REREAD,
		PH_HALT
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [31:0] base_q, base_n;
	logic [31:0] ptr_q, ptr_n;
	logic [31:0] remain_q, remain_n;
	logic [15:0] high_q, high_n;
	logic [15:0] cur_q, cur_n;
	logic        half_sel_q, half_sel_n;
	logic        accept;
	logic        job_v;
	job_t        job;
	logic [31:0] ptr_inc;
	logic [31:0] remain_dec;
	logic        pass_poll;
	logic        pass_reread;

	assign in_ready    = !queue_full;
	assign accept      = in_valid && in_ready;
	assign ptr_inc     = ptr_q + 32'd2;
	assign remain_dec  = remain_q - 32'd1;
	assign pass_poll   = (cur_q & POLL_MASK) == (flash_read_data & POLL_MASK);
	assign pass_reread = cur_q[DQ7_BIT] == flash_read_data[DQ7_BIT];

	always_comb begin
		phase_n    = phase_q;
		base_n     = base_q;
		ptr_n      = ptr_q;
		remain_n   = remain_q;
		high_n     = high_q;
		cur_n      = cur_q;
		half_sel_n = half_sel_q;
		job_v      = 1'b0;
		job.kind   = JOB_READ;
		job.base   = base_q;
		job.ptr    = ptr_q;
		job.data   = cur_q;
		case (phase_q)
			PH_IDLE: begin
				if (!req_type && host_word == TOKEN_START) begin
					phase_n = PH_BASE;
				end
			end
			PH_BASE: begin
				if (!req_type) begin
					base_n  = host_word;
					phase_n = PH_ADDR;
				end
			end
			PH_ADDR: begin
				if (!req_type) begin
					ptr_n   = host_word;
					phase_n = PH_LEN;
				end
			end
			PH_LEN: begin
				if (!req_type) begin
					remain_n   = host_word;
					half_sel_n = 1'b0;
					job_v      = 1'b1;
					if (host_word == 32'd0) begin
						job.kind = JOB_ACK_FIN;
						phase_n  = PH_HALT;
					end else begin
						job.kind = JOB_ACK;
						phase_n  = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (!req_type) begin
					cur_n      = host_word[15:0];
					high_n     = host_word[31:16];
					half_sel_n = 1'b0;
					job_v      = 1'b1;
					job.kind   = JOB_PROG;
					job.data   = host_word[15:0];
					phase_n    = PH_POLL;
				end
			end
			PH_POLL, PH_REREAD: begin
				if (req_type) begin
					if ((phase_q == PH_POLL) ? pass_poll : pass_reread) begin
						ptr_n = ptr_inc;
						if (!half_sel_q) begin
							half_sel_n = 1'b1;
							cur_n      = high_q;
							job_v      = 1'b1;
							job.kind   = JOB_PROG;
							job.ptr    = ptr_inc;
							job.data   = high_q;
							phase_n    = PH_POLL;
						end else begin
							half_sel_n = 1'b0;
							remain_n   = remain_dec;
							if (remain_dec == 32'd0) begin
								job_v    = 1'b1;
								job.kind = JOB_FIN;
								phase_n  = PH_HALT;
							end else begin
								phase_n = PH_DATA;
							end
						end
					end else if (phase_q == PH_POLL) begin
						job_v    = 1'b1;
						job.kind = JOB_READ;
						if (flash_read_data[DQ5_BIT]) begin
							phase_n = PH_REREAD;
						end
					end else begin
						job_v    = 1'b1;
						job.kind = JOB_NACK;
						phase_n  = PH_HALT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign push     = accept && job_v;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			base_q     <= '0;
			ptr_q      <= '0;
			remain_q   <= '0;
			high_q     <= '0;
			cur_q      <= '0;
			half_sel_q <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_n;
			base_q     <= base_n;
			ptr_q      <= ptr_n;
			remain_q   <= remain_n;
			high_q     <= high_n;
			cur_q      <= cur_n;
			half_sel_q <= half_sel_n;
		end
	end

endmodule
`default_nettype wire

### src/fhpl_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Flash halfword program loader job queue
// Small first-in first-out buffer of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module fhpl_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire fhpl_pkg::job_t  push_job,
	output logic                 full,
	input  wire logic            pop,
	output fhpl_pkg::job_t       head_job,
	output logic                 empty
);
	import fhpl_pkg::*;

	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          slots_q [DEPTH];
	logic [IW-1:0] wr_q;
	logic [IW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full     = cnt_q == CW'(DEPTH);
	assign empty    = cnt_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == IW'(DEPTH - 1)) ? '0 : wr_q + IW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == IW'(DEPTH - 1)) ? '0 : rd_q + IW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### src/fhpl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Flash halfword program loader back end
// Expands each job into its sequence of output words through an output
// register.
// ----------------------------------------------------------------------------
module fhpl_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fhpl_pkg::job_t  head_job,
	input  wire logic            empty,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [1:0]           op_kind,
	output logic [31:0]          bus_address,
	output logic [31:0]          bus_data,
	output logic                 last
);
	import fhpl_pkg::*;

	logic [2:0]  step_q;
	logic        valid_q;
	logic [1:0]  kind_q;
	logic [31:0] addr_q;
	logic [31:0] data_q;
	logic        last_q;
	logic        load;
	logic [1:0]  r_kind;
	logic [31:0] r_addr;
	logic [31:0] r_data;
	logic        r_last;
	logic [31:0] cmd1_addr;
	logic [31:0] cmd2_addr;

	assign cmd1_addr = head_job.base + OFS_CMD1;
	assign cmd2_addr = head_job.base + OFS_CMD2;

	always_comb begin
		r_kind = OP_REPLY;
		r_addr = '0;
		r_data = '0;
		r_last = 1'b1;
		case (head_job.kind)
			JOB_ACK: begin
				r_data = REPLY_ACK;
			end
			JOB_ACK_FIN: begin
				r_data = (step_q == 3'd0) ? REPLY_ACK : REPLY_FIN;
				r_last = step_q != 3'd0;
			end
			JOB_PROG: begin
				r_kind = OP_WRITE;
				r_last = 1'b0;
				case (step_q)
					3'd0: begin
						r_addr = cmd1_addr;
						r_data = {16'd0, CMD_UNLOCK1};
					end
					3'd1: begin
						r_addr = cmd2_addr;
						r_data = {16'd0, CMD_UNLOCK2};
					end
					3'd2: begin
						r_addr = cmd1_addr;
						r_data = {16'd0, CMD_PROGRAM};
					end
					3'd3: begin
						r_addr = head_job.ptr;
						r_data = {16'd0, head_job.data};
					end
					default: begin
						r_kind = OP_READ;
						r_addr = head_job.ptr;
						r_last = 1'b1;
					end
				endcase
			end
			JOB_READ: begin
				r_kind = OP_READ;
				r_addr = head_job.ptr;
			end
			JOB_FIN: begin
				r_data = REPLY_FIN;
			end
			JOB_NACK: begin
				if (step_q == 3'd0) begin
					r_kind = OP_WRITE;
					r_addr = cmd1_addr;
					r_data = {16'd0, CMD_RESET};
					r_last = 1'b0;
				end else begin
					r_data = REPLY_NACK;
				end
			end
			default: begin
			end
		endcase
	end

	assign load = !empty && (!valid_q || out_ready);
	assign pop  = load && r_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= r_last ? 3'd0 : step_q + 3'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= r_kind;
			addr_q <= r_addr;
			data_q <= r_data;
			last_q <= r_last;
		end
	end

	assign out_valid   = valid_q;
	assign op_kind     = kind_q;
	assign bus_address = addr_q;
	assign bus_data    = data_q;
	assign last        = last_q;

endmodule
`default_nettype wire

### src/flash_halfword_program_loader_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Flash halfword program loader unit
// Programs host data into an AMD-style flash, halfword by halfword, with
// data polling, and answers the host with status words.
// ----------------------------------------------------------------------------
// The unit accepts one input word per cycle while its job queue has room and
// drives one output word per cycle while jobs are queued and the consumer
// takes them. An input word produces zero to five output words: five for a
// halfword program sequence, two for a reset with its reply or for an
// acknowledge with a finish reply, one for a poll read or a single reply. The
// output port is the limiting resource; the job queue lets the input side keep
// running while a long sequence drains.
module flash_halfword_program_loader_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [47:0]  s_tdata,   // host_word, flash_read_data
	input  wire logic [0:0]   s_tuser,   // req_type
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [63:0]       m_tdata,   // bus_address, bus_data
	output logic [1:0]        m_tuser,   // op_kind
	output logic              m_tlast
);
	import fhpl_pkg::*;

	logic        queue_full;
	logic        queue_empty;
	logic        push;
	logic        pop;
	job_t        push_job;
	job_t        head_job;
	logic [31:0] bus_address;
	logic [31:0] bus_data;

	fhpl_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.req_type        (s_tuser[0]),
		.host_word       (s_tdata[31:0]),
		.flash_read_data (s_tdata[47:32]),
		.queue_full      (queue_full),
		.push            (push),
		.push_job        (push_job)
	);

	fhpl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.head_job (head_job),
		.empty    (queue_empty)
	);

	fhpl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_job    (head_job),
		.empty       (queue_empty),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.op_kind     (m_tuser),
		.bus_address (bus_address),
		.bus_data    (bus_data),
		.last        (m_tlast)
	);

	assign m_tdata = {bus_data, bus_address};

endmodule
`default_nettype wire
